@@ design/frrs_pkg.sv @@
// Package for the feedback round-robin scheduler.
// Holds payload structs, state and event codes, queue and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package frrs_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int PID_BITS_DEF    = 8;

    // Reset values of the configuration registers
    localparam logic [7:0] QLEN_RST    = 8'd4;
    localparam logic [3:0] DISK_RST    = 4'd4;
    localparam logic [3:0] TAPE_RST    = 4'd6;
    localparam logic [3:0] PRINTER_RST = 4'd8;

    // Configuration register indexes
    localparam logic [1:0] CFG_QLEN    = 2'd0;
    localparam logic [1:0] CFG_DISK    = 2'd1;
    localparam logic [1:0] CFG_TAPE    = 2'd2;
    localparam logic [1:0] CFG_PRINTER = 2'd3;

    // Queue indexes
    localparam logic [1:0] Q_HI = 2'd0;
    localparam logic [1:0] Q_LO = 2'd1;
    localparam logic [1:0] Q_IO = 2'd2;

    // Device codes
    localparam logic [1:0] DEV_NONE    = 2'd0;
    localparam logic [1:0] DEV_DISK    = 2'd1;
    localparam logic [1:0] DEV_TAPE    = 2'd2;
    localparam logic [1:0] DEV_PRINTER = 2'd3;

    typedef enum logic [2:0] {
        EV_IDLE     = 3'd0,
        EV_CONTINUE = 3'd1,
        EV_FINISHED = 3'd2,
        EV_TO_IO    = 3'd3,
        EV_ROTATED  = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_RUN,
        S_IOST,
        S_IORD,
        S_IOWR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       arrival_valid;
        logic [7:0] arrival_pid;
        logic [7:0] arrival_burst;
        logic       arrival_high;
        logic [1:0] arrival_device;
    } t_in;

    typedef struct packed {
        logic       run_valid;
        logic [7:0] run_pid;
        logic [7:0] run_remaining;
        logic [2:0] run_event;
        logic       arrival_dropped;
        logic [3:0] high_count;
        logic [3:0] low_count;
        logic [3:0] io_count;
    } t_out;

endpackage

@@ design/frrs_qmem.sv @@
// Queue storage for one process-record queue: one write port, one
// registered read port. Depends on nothing.
`timescale 1ns / 1ps

module frrs_qmem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 22
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ design/feedback_round_robin_scheduler.sv @@
// Top level of the feedback round-robin scheduler: tick sequencer and queues.
// Depends on frrs_pkg and frrs_qmem.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one time tick,
//   optionally with an arriving process. Output channel (o_out_valid /
//   i_out_ready / o_out_data) returns exactly one result per tick.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data) writes quantum and I/O times; it is always ready.
// Tick sequence:
//   An accepted tick steps through S_SEL, S_RUN (skipped when nothing runs),
//   S_IOST, one S_IORD/S_IOWR pair per I/O queue entry after the run step
//   (N of them, 0..QUEUE_DEPTH) and S_OUT. The walk reads and rewrites one
//   entry at a time via the single registered read port of the I/O queue
//   memory. The next tick is accepted the cycle after the result is taken.
// Reset:
//   i_rst_n low empties all queues, clears the running process and loads
//   the default register values; no clearing pass is needed.
// Stall:
//   The result is held in place while i_out_ready is low and no new tick
//   is accepted until it has been taken.

module feedback_round_robin_scheduler #(
    parameter int QUEUE_DEPTH = frrs_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = frrs_pkg::PID_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  frrs_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output frrs_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data
);

    import frrs_pkg::*;

    localparam int D  = QUEUE_DEPTH;
    localparam int PW = $clog2(D);
    localparam int CW = $clog2(D + 1);
    localparam int RW = PID_BITS + 14;

    // Queue index arithmetic with wrap at D
    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] h, input logic [CW-1:0] o);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(o);
        if (s >= (CW+1)'(D)) s = s - (CW+1)'(D);
        return s[PW-1:0];
    endfunction

    // Configuration registers
    logic [7:0] r_qlen;
    logic [3:0] r_disk, r_tape, r_printer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen    <= QLEN_RST;
            r_disk    <= DISK_RST;
            r_tape    <= TAPE_RST;
            r_printer <= PRINTER_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_QLEN:    r_qlen    <= i_cfg_data;
                CFG_DISK:    r_disk    <= i_cfg_data[3:0];
                CFG_TAPE:    r_tape    <= i_cfg_data[3:0];
                CFG_PRINTER: r_printer <= i_cfg_data[3:0];
                default:     r_qlen    <= r_qlen;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Queue memories
    logic          mem_we    [3];
    logic [PW-1:0] mem_waddr [3];
    logic [RW-1:0] mem_wdata [3];
    logic [PW-1:0] mem_raddr [3];
    logic [RW-1:0] mem_rdata [3];

    for (genvar g = 0; g < 3; g++) begin : g_q
        frrs_qmem #(.DEPTH(D), .WIDTH(RW)) u_qmem (
            .i_clk   (i_clk),
            .i_we    (mem_we[g]),
            .i_waddr (mem_waddr[g]),
            .i_wdata (mem_wdata[g]),
            .i_raddr (mem_raddr[g]),
            .o_rdata (mem_rdata[g])
        );
    end

    // Sequencer state
    t_state        r_state, n_state;
    logic [PW-1:0] r_head [3];
    logic [PW-1:0] n_head [3];
    logic [CW-1:0] r_cnt  [3];
    logic [CW-1:0] n_cnt  [3];
    logic          r_active, n_active, r_from_hi, n_from_hi;
    logic [7:0]    r_qused, n_qused;
    logic [CW-1:0] r_i, n_i, r_w, n_w, r_n, n_n;
    logic          r_rv, n_rv, r_drop, n_drop;
    logic [7:0]    r_pid, n_pid, r_rem, n_rem;
    t_event        r_ev, n_ev;

    // Read addresses: run reads the heads, the walk reads entry i
    assign mem_raddr[Q_HI] = r_head[Q_HI];
    assign mem_raddr[Q_LO] = r_head[Q_LO];
    assign mem_raddr[Q_IO] = wrap(r_head[Q_IO], r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= 1'b0;
            r_from_hi <= 1'b0;
            r_qused   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_from_hi <= n_from_hi;
            r_qused   <= n_qused;
            for (int k = 0; k < 3; k++) begin
                r_head[k] <= n_head[k];
                r_cnt[k]  <= n_cnt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_w    <= n_w;
        r_n    <= n_n;
        r_rv   <= n_rv;
        r_drop <= n_drop;
        r_pid  <= n_pid;
        r_rem  <= n_rem;
        r_ev   <= n_ev;
    end

    // Sequencer next state and datapath
    always_comb begin
        logic [1:0]    q, oq, tq;
        logic [RW-1:0] c;
        logic [RW-1:0] e;
        logic [7:0]    rem;
        logic [7:0]    qu;
        logic [3:0]    iot;
        logic [15:0]   pid_ext;
        logic [15:0]   pid_out;
        logic          act;
        n_state   = r_state;
        n_active  = r_active;
        n_from_hi = r_from_hi;
        n_qused   = r_qused;
        n_i = r_i;
        n_w = r_w;
        n_n = r_n;
        n_rv = r_rv;
        n_drop = r_drop;
        n_pid = r_pid;
        n_rem = r_rem;
        n_ev = r_ev;
        for (int k = 0; k < 3; k++) begin
            n_head[k]    = r_head[k];
            n_cnt[k]     = r_cnt[k];
            mem_we[k]    = 1'b0;
            mem_waddr[k] = '0;
            mem_wdata[k] = '0;
        end
        q   = r_from_hi ? Q_HI : Q_LO;
        oq  = r_from_hi ? Q_LO : Q_HI;
        c   = mem_rdata[q];
        e   = mem_rdata[Q_IO];
        tq  = (e[5:4] == DEV_DISK) ? Q_LO : Q_HI;
        rem = (c[13:6] != 8'd0) ? c[13:6] - 8'd1 : 8'd0;
        qu  = (r_qused != 8'hFF) ? r_qused + 8'd1 : r_qused;
        iot = 4'd0;
        case (i_in_data.arrival_device)
            DEV_DISK:    iot = r_disk;
            DEV_TAPE:    iot = r_tape;
            DEV_PRINTER: iot = r_printer;
            default:     iot = 4'd0;
        endcase
        pid_ext = 16'(i_in_data.arrival_pid);
        pid_out = 16'(c[RW-1:14]);
        act = r_active;

        unique case (r_state)
            // Take a tick and enqueue its arrival
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rv   = 1'b0;
                    n_pid  = '0;
                    n_rem  = '0;
                    n_ev   = EV_IDLE;
                    n_drop = 1'b0;
                    if (i_in_data.arrival_valid) begin
                        tq = i_in_data.arrival_high ? Q_HI : Q_LO;
                        if (r_cnt[tq] < CW'(D)) begin
                            mem_we[tq]    = 1'b1;
                            mem_waddr[tq] = wrap(r_head[tq], r_cnt[tq]);
                            mem_wdata[tq] = {pid_ext[PID_BITS-1:0],
                                             i_in_data.arrival_burst,
                                             i_in_data.arrival_device, iot};
                            n_cnt[tq]     = r_cnt[tq] + CW'(1);
                        end else begin
                            n_drop = 1'b1;
                        end
                    end
                    n_state = S_SEL;
                end
            end
            // Select the running process
            S_SEL: begin
                if (act && r_cnt[q] == '0) act = 1'b0;
                if (!act) begin
                    n_qused = '0;
                    if (r_cnt[Q_HI] != '0) begin
                        act = 1'b1;
                        n_from_hi = 1'b1;
                    end else if (r_cnt[Q_LO] != '0) begin
                        act = 1'b1;
                        n_from_hi = 1'b0;
                    end
                end
                n_active = act;
                n_state  = act ? S_RUN : S_IOST;
            end
            // Run the head for one unit
            S_RUN: begin
                n_rv  = 1'b1;
                n_pid = pid_out[7:0];
                n_rem = rem;
                n_ev  = EV_CONTINUE;
                n_qused = qu;
                if (rem == 8'd0) begin
                    n_ev = EV_FINISHED;
                end else if (c[5:4] != DEV_NONE) begin
                    if (r_cnt[Q_IO] < CW'(D)) begin
                        mem_we[Q_IO]    = 1'b1;
                        mem_waddr[Q_IO] = wrap(r_head[Q_IO], r_cnt[Q_IO]);
                        mem_wdata[Q_IO] = {c[RW-1:14], rem, c[5:0]};
                        n_cnt[Q_IO]     = r_cnt[Q_IO] + CW'(1);
                        n_ev = EV_TO_IO;
                    end
                end else if (qu >= r_qlen) begin
                    if (r_cnt[oq] < CW'(D)) begin
                        mem_we[oq]    = 1'b1;
                        mem_waddr[oq] = wrap(r_head[oq], r_cnt[oq]);
                        mem_wdata[oq] = {c[RW-1:14], rem, c[5:0]};
                        n_cnt[oq]     = r_cnt[oq] + CW'(1);
                        n_ev = EV_ROTATED;
                    end
                end
                if (n_ev == EV_CONTINUE) begin
                    mem_we[q]    = 1'b1;
                    mem_waddr[q] = r_head[q];
                    mem_wdata[q] = {c[RW-1:14], rem, c[5:0]};
                end else begin
                    n_head[q] = wrap(r_head[q], CW'(1));
                    n_cnt[q]  = r_cnt[q] - CW'(1);
                    n_active  = 1'b0;
                    n_qused   = '0;
                end
                n_state = S_IOST;
            end
            // Start the I/O walk
            S_IOST: begin
                n_i = '0;
                n_w = '0;
                n_n = r_cnt[Q_IO];
                n_state = (r_cnt[Q_IO] == '0) ? S_OUT : S_IORD;
            end
            // Wait for the I/O entry read
            S_IORD: begin
                n_state = S_IOWR;
            end
            // Count down, return, or keep (target queue full) one I/O entry
            S_IOWR: begin
                if (e[3:0] != 4'd0) begin
                    mem_we[Q_IO]    = 1'b1;
                    mem_waddr[Q_IO] = wrap(r_head[Q_IO], r_w);
                    mem_wdata[Q_IO] = {e[RW-1:4], e[3:0] - 4'd1};
                    n_w = r_w + CW'(1);
                end else if (r_cnt[tq] < CW'(D)) begin
                    mem_we[tq]    = 1'b1;
                    mem_waddr[tq] = wrap(r_head[tq], r_cnt[tq]);
                    mem_wdata[tq] = {e[RW-1:6], DEV_NONE, 4'd0};
                    n_cnt[tq]     = r_cnt[tq] + CW'(1);
                end else begin
                    mem_we[Q_IO]    = 1'b1;
                    mem_waddr[Q_IO] = wrap(r_head[Q_IO], r_w);
                    mem_wdata[Q_IO] = e;
                    n_w = r_w + CW'(1);
                end
                n_i = r_i + CW'(1);
                if (n_i == r_n) begin
                    n_cnt[Q_IO] = n_w;
                    n_state = S_OUT;
                end else begin
                    n_state = S_IORD;
                end
            end
            // Present the result
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshakes and result
    logic [7:0] hc, lc, ic;
    assign hc = 8'(r_cnt[Q_HI]);
    assign lc = 8'(r_cnt[Q_LO]);
    assign ic = 8'(r_cnt[Q_IO]);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    always_comb begin
        o_out_data.run_valid       = r_rv;
        o_out_data.run_pid         = r_pid;
        o_out_data.run_remaining   = r_rem;
        o_out_data.run_event       = r_ev;
        o_out_data.arrival_dropped = r_drop;
        o_out_data.high_count      = hc[3:0];
        o_out_data.low_count       = lc[3:0];
        o_out_data.io_count        = ic[3:0];
    end

`ifndef SYNTHESIS
    // Queue counts stay within depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[Q_HI] <= CW'(D) && r_cnt[Q_LO] <= CW'(D) && r_cnt[Q_IO] <= CW'(D))
        else $error("queue count above depth");
    // Walk never writes ahead of its read point
    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IOWR |-> r_w <= r_i && r_i < r_n)
        else $error("I/O walk pointers out of order");
    // An idle result never names a process
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_rv |-> r_ev == EV_IDLE && r_pid == 8'd0)
        else $error("idle result carries a process");
    // A result held under stall does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");
`endif

endmodule

@@ verif/tb_feedback_round_robin_scheduler.sv @@
// Testbench for the feedback round-robin scheduler: directed table, then random ticks.
// Checks each result against its directed table row or a scheduler model here. Depends on frrs_pkg.
`timescale 1ns / 1ps

module tb_feedback_round_robin_scheduler;
    import frrs_pkg::*;

    localparam int DEPTH = 8;

    typedef struct packed {
        logic [7:0] pid;
        logic [7:0] rem;
        logic [1:0] dev;
        logic [3:0] iot;
    } t_proc;

    typedef struct {
        t_in  stim;
        bit   typed;
        t_out res;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready, o_out_valid, i_out_ready;
    t_in  i_in_data;
    t_out o_out_data;
    logic i_cfg_valid, o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    feedback_round_robin_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Scheduler model state
    t_proc hi_q[DEPTH], lo_q[DEPTH], io_q[DEPTH];
    int    hi_n, lo_n, io_n;
    bit    busy, busy_hi;
    int    slice_used;
    logic [7:0] m_quantum;
    logic [3:0] m_disk, m_tape, m_printer;

    t_out  pending_results[$];
    int    errors, ticks, n_fin, n_io, n_rot, n_drop;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20ms;
        $display("tb_feedback_round_robin_scheduler: errors");
        $finish;
    end

    function automatic bit q_push(int q, t_proc r);
        case (q)
            Q_HI: begin
                if (hi_n >= DEPTH) return 0;
                hi_q[hi_n] = r; hi_n++;
            end
            Q_LO: begin
                if (lo_n >= DEPTH) return 0;
                lo_q[lo_n] = r; lo_n++;
            end
            default: begin
                if (io_n >= DEPTH) return 0;
                io_q[io_n] = r; io_n++;
            end
        endcase
        return 1;
    endfunction

    function automatic void q_pop_head(bit from_hi);
        if (from_hi) begin
            for (int i = 0; i < hi_n - 1; i++) hi_q[i] = hi_q[i+1];
            hi_n--;
        end else begin
            for (int i = 0; i < lo_n - 1; i++) lo_q[i] = lo_q[i+1];
            lo_n--;
        end
    endfunction

    // One scheduler tick: arrival, selection, one unit of run, I/O walk
    function automatic t_out schedule_tick(t_in a);
        t_out  r;
        t_proc p, cur, e;
        int    other, kept;
        bit    gone;
        r = '0;
        if (a.arrival_valid) begin
            p.pid = a.arrival_pid;
            p.rem = a.arrival_burst;
            p.dev = a.arrival_device;
            case (a.arrival_device)
                DEV_DISK:    p.iot = m_disk;
                DEV_TAPE:    p.iot = m_tape;
                DEV_PRINTER: p.iot = m_printer;
                default:     p.iot = '0;
            endcase
            if (!q_push(a.arrival_high ? Q_HI : Q_LO, p)) r.arrival_dropped = 1'b1;
        end
        if (busy && (busy_hi ? hi_n : lo_n) == 0) busy = 0;
        if (!busy) begin
            if (hi_n > 0) begin
                busy = 1; busy_hi = 1;
            end else if (lo_n > 0) begin
                busy = 1; busy_hi = 0;
            end
            slice_used = 0;
        end
        if (busy) begin
            other = busy_hi ? Q_LO : Q_HI;
            if (busy_hi) begin
                if (hi_q[0].rem > 0) hi_q[0].rem--;
                cur = hi_q[0];
            end else begin
                if (lo_q[0].rem > 0) lo_q[0].rem--;
                cur = lo_q[0];
            end
            if (slice_used < 255) slice_used++;
            r.run_valid = 1'b1;
            r.run_pid = cur.pid;
            r.run_remaining = cur.rem;
            r.run_event = EV_CONTINUE;
            gone = 0;
            if (cur.rem == 0) begin
                q_pop_head(busy_hi);
                r.run_event = EV_FINISHED;
                gone = 1;
            end else if (cur.dev != DEV_NONE) begin
                if (io_n < DEPTH) begin
                    q_pop_head(busy_hi);
                    void'(q_push(Q_IO, cur));
                    r.run_event = EV_TO_IO;
                    gone = 1;
                end
            end else if (slice_used >= m_quantum) begin
                if ((other == Q_HI ? hi_n : lo_n) < DEPTH) begin
                    q_pop_head(busy_hi);
                    void'(q_push(other, cur));
                    r.run_event = EV_ROTATED;
                    gone = 1;
                end
            end
            if (gone) begin
                busy = 0;
                slice_used = 0;
            end
        end
        // I/O walk: count down, or return to low (disk) / high (others), kept if that queue is full
        kept = 0;
        for (int i = 0; i < io_n; i++) begin
            e = io_q[i];
            if (e.iot > 0) begin
                e.iot--;
                io_q[kept++] = e;
            end else begin
                p = e;
                p.dev = DEV_NONE;
                p.iot = '0;
                if (!q_push(e.dev == DEV_DISK ? Q_LO : Q_HI, p)) io_q[kept++] = e;
            end
        end
        io_n = kept;
        r.high_count = hi_n[3:0];
        r.low_count  = lo_n[3:0];
        r.io_count   = io_n[3:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        errors++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    endtask

    // Result side: stall pattern and checking
    initial begin
        int mode;
        int cyc;
        i_out_ready = 1'b0;
        mode = 0;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 50 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 1);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= ((cyc % 7) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("outstanding requests", 0, 1);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.run_valid !== want.run_valid)
                    report_mismatch("run_valid", o_out_data.run_valid, want.run_valid);
                if (o_out_data.run_pid !== want.run_pid)
                    report_mismatch("run_pid", o_out_data.run_pid, want.run_pid);
                if (o_out_data.run_remaining !== want.run_remaining)
                    report_mismatch("run_remaining", o_out_data.run_remaining,
                                    want.run_remaining);
                if (o_out_data.run_event !== want.run_event)
                    report_mismatch("run_event", o_out_data.run_event, want.run_event);
                if (o_out_data.arrival_dropped !== want.arrival_dropped)
                    report_mismatch("arrival_dropped", o_out_data.arrival_dropped,
                                    want.arrival_dropped);
                if (o_out_data.high_count !== want.high_count)
                    report_mismatch("high_count", o_out_data.high_count, want.high_count);
                if (o_out_data.low_count !== want.low_count)
                    report_mismatch("low_count", o_out_data.low_count, want.low_count);
                if (o_out_data.io_count !== want.io_count)
                    report_mismatch("io_count", o_out_data.io_count, want.io_count);
                case (want.run_event)
                    EV_FINISHED: n_fin++;
                    EV_TO_IO:    n_io++;
                    EV_ROTATED:  n_rot++;
                    default: ;
                endcase
                if (want.arrival_dropped) n_drop++;
            end
        end
    end

    // Register write while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_QLEN:    m_quantum = val;
            CFG_DISK:    m_disk    = val[3:0];
            CFG_TAPE:    m_tape    = val[3:0];
            default:     m_printer = val[3:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, drain, then rewrite all registers
    task automatic set_config(logic [7:0] q, logic [3:0] d, logic [3:0] t, logic [3:0] p);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (30) @(negedge i_clk);
        write_reg(CFG_QLEN, q);
        write_reg(CFG_DISK, {4'($urandom), d});
        write_reg(CFG_TAPE, {4'($urandom), t});
        write_reg(CFG_PRINTER, {4'($urandom), p});
    endtask

    // Send one tick; valid is held, then dropped for a random gap between bursts
    int burst_left;
    task automatic send_tick(t_in a, bit typed, t_out res);
        t_out predicted;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= a;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = schedule_tick(a);
        pending_results.push_back(typed ? res : predicted);
        ticks++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    function automatic t_in random_tick(int load_pct);
        t_in a;
        a.arrival_valid  = ($urandom_range(0, 99) < load_pct);
        a.arrival_pid    = 8'($urandom);
        a.arrival_burst  = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                           8'($urandom_range(0, 12));
        a.arrival_high   = 1'($urandom);
        a.arrival_device = 2'($urandom);
        return a;
    endfunction

    t_row rows[$];

    initial begin
        t_row row;
        t_in  a;
        int   load;
        errors = 0; ticks = 0; n_fin = 0; n_io = 0; n_rot = 0; n_drop = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_QLEN;
        i_cfg_data = '0;
        hi_n = 0; lo_n = 0; io_n = 0;
        busy = 0; busy_hi = 0; slice_used = 0;
        m_quantum = QLEN_RST; m_disk = DISK_RST; m_tape = TAPE_RST; m_printer = PRINTER_RST;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: idle tick, zero burst, extremes, each device, queue overflow, then idle ticks
        row.typed = 1; row.stim = '0; row.res = '0;
        rows.push_back(row);
        row.stim = '{1'b1, 8'hFF, 8'h00, 1'b1, DEV_NONE};
        row.res  = '{1'b1, 8'hFF, 8'h00, EV_FINISHED, 1'b0, 4'd0, 4'd0, 4'd0};
        rows.push_back(row);
        row.stim = '{1'b1, 8'h00, 8'hFF, 1'b0, DEV_PRINTER};
        row.res  = '{1'b1, 8'h00, 8'hFE, EV_TO_IO, 1'b0, 4'd0, 4'd0, 4'd1};
        rows.push_back(row);
        row.typed = 0;
        row.stim = '{1'b1, 8'h5A, 8'h03, 1'b1, DEV_DISK};    rows.push_back(row);
        row.stim = '{1'b1, 8'hA5, 8'h05, 1'b0, DEV_TAPE};    rows.push_back(row);
        row.stim = '{1'b1, 8'h3C, 8'h06, 1'b0, DEV_NONE};    rows.push_back(row);
        for (int i = 0; i < 10; i++) begin
            row.stim = '{1'b1, 8'(8'h10 + i), 8'd200, 1'b0, DEV_NONE};
            rows.push_back(row);
        end
        for (int i = 0; i < 6; i++) begin
            row.stim = '{1'b0, 8'hC3, 8'h7E, 1'b1, DEV_PRINTER};
            rows.push_back(row);
        end
        foreach (rows[i]) send_tick(rows[i].stim, rows[i].typed, rows[i].res);

        // Random phases over several register settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: ;
                1: set_config(8'd0, 4'd0, 4'd0, 4'd0);
                2: set_config(8'd255, 4'd15, 4'd15, 4'd15);
                3: set_config(8'd1, 4'd15, 4'd0, 4'd7);
                default: set_config(8'($urandom_range(1, 8)), 4'($urandom),
                                    4'($urandom), 4'($urandom));
            endcase
            load = 60;
            for (int i = 0; i < 190; i++) begin
                if (i % 40 == 0) load = ($urandom_range(0, 1) == 1) ? 90 : 25;
                a = random_tick(load);
                send_tick(a, 0, '0);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (40) @(negedge i_clk);
        $display("Ran %0d ticks: %0d finished, %0d sent to I/O, %0d rotated, %0d drops.",
                 ticks, n_fin, n_io, n_rot, n_drop);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_feedback_round_robin_scheduler: clean");
        else
            $display("tb_feedback_round_robin_scheduler: errors");
        $finish;
    end

endmodule
